### hdl/iaf_pkg.sv
`default_nettype none

package iaf_pkg;

	localparam int VALUE_BITS = 32;
	localparam int DIGITS     = 11;
	localparam int STORE_BITS = 4 * DIGITS;
	localparam int WIDTH_BITS = 7;

	localparam logic [1:0] OP_DEC = 2'd0;
	localparam logic [1:0] OP_HEX = 2'd1;
	localparam logic [1:0] OP_OCT = 2'd2;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ALPHA = 8'h41;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [1:0]            operation;
		logic [WIDTH_BITS-1:0] width;
		logic                  left_adjust;
		logic                  zero_pad;
	} iaf_item_t;

	typedef struct packed {
		logic [STORE_BITS-1:0] digits;
		logic [3:0]            count;
		logic                  neg;
		logic [WIDTH_BITS-1:0] width;
		logic                  left_adjust;
		logic                  zero_pad;
	} iaf_conv_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10)
			c = CH_ZERO + {4'b0, d};
		else
			c = CH_ALPHA + {4'b0, d} - 8'd10;
		return c;
	endfunction

endpackage

`default_nettype wire

### hdl/iaf_if.sv
`default_nettype none

interface iaf_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] value;
	logic [1:0]  operation;
	logic [5:0]  field_width;
	logic        left_adjust;
	logic        zero_pad;

	modport source (output valid, value, operation, field_width, left_adjust, zero_pad,
		input ready);
	modport sink (input valid, value, operation, field_width, left_adjust, zero_pad,
		output ready);
endinterface

interface iaf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last;

	modport source (output valid, character, last, input ready);
	modport sink (input valid, character, last, output ready);
endinterface

`default_nettype wire

### hdl/iaf_conv.sv
`default_nettype none

module iaf_conv import iaf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  iaf_item_t item,
	output logic      ready,
	output logic      res_valid,
	input  logic      res_take,
	output iaf_conv_t res
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DAB  = 2'd1;
	localparam logic [1:0] ST_NORM = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]            state_q;
	logic [4:0]            step_q;
	logic [3:0]            count_q;
	logic [VALUE_BITS-1:0] mag_q;
	logic [STORE_BITS-1:0] digits_q;
	logic                  neg_q;
	logic [WIDTH_BITS-1:0] width_q;
	logic                  ladj_q;
	logic                  zpad_q;

	logic                  neg_in;
	logic [VALUE_BITS-1:0] mag_in;
	logic [STORE_BITS-1:0] adj;
	logic [STORE_BITS-1:0] oct_digits;
	logic [3*DIGITS-1:0]   value_ext;
	logic                  norm_shift;

	assign neg_in     = (item.operation == OP_DEC) && item.value[VALUE_BITS-1];
	assign mag_in     = neg_in ? (~item.value + VALUE_BITS'(1)) : item.value;
	assign value_ext  = {{(3*DIGITS-VALUE_BITS){1'b0}}, item.value};
	assign norm_shift = (count_q > 4'd1) && (digits_q[STORE_BITS-1 -: 4] == 4'd0);

	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			adj[4*i +: 4] = (digits_q[4*i +: 4] >= 4'd5) ?
				(digits_q[4*i +: 4] + 4'd3) : digits_q[4*i +: 4];
			oct_digits[4*i +: 4] = {1'b0, value_ext[3*i +: 3]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						count_q <= 4'(DIGITS);
						step_q  <= 5'(VALUE_BITS - 1);
						state_q <= (item.operation == OP_DEC) ? ST_DAB : ST_NORM;
					end
				end
				ST_DAB: begin
					step_q <= step_q - 5'd1;
					if (step_q == 5'd0)
						state_q <= ST_NORM;
				end
				ST_NORM: begin
					if (norm_shift)
						count_q <= count_q - 4'd1;
					else
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			neg_q   <= neg_in;
			width_q <= item.width;
			ladj_q  <= item.left_adjust;
			zpad_q  <= item.zero_pad;
			mag_q   <= mag_in;
			if (item.operation == OP_DEC)
				digits_q <= '0;
			else if (item.operation == OP_OCT)
				digits_q <= oct_digits;
			else
				digits_q <= {{(STORE_BITS-VALUE_BITS){1'b0}}, item.value};
		end else if (state_q == ST_DAB) begin
			digits_q <= {adj[STORE_BITS-2:0], mag_q[VALUE_BITS-1]};
			mag_q    <= {mag_q[VALUE_BITS-2:0], 1'b0};
		end else if (state_q == ST_NORM && norm_shift) begin
			digits_q <= {digits_q[STORE_BITS-5:0], 4'd0};
		end
	end

	assign ready     = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res       = '{digits: digits_q, count: count_q, neg: neg_q, width: width_q,
		left_adjust: ladj_q, zero_pad: zpad_q};

endmodule

`default_nettype wire

### hdl/iaf_emit.sv
`default_nettype none

module iaf_emit import iaf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  iaf_conv_t src,
	output logic      idle,
	iaf_out_if.source out_ch
);

	logic [WIDTH_BITS-1:0] tot_q;
	logic [WIDTH_BITS-1:0] fill_q;
	logic [3:0]            dig_q;
	logic                  sign_q;
	logic [STORE_BITS-1:0] digits_q;
	logic                  ladj_q;
	logic                  zpad_q;
	logic                  out_valid_q;
	logic [7:0]            char_q;
	logic                  last_q;

	logic [WIDTH_BITS-1:0] tlen;
	logic [WIDTH_BITS-1:0] tot_in;
	logic                  advance;
	logic [7:0]            fill_ch;
	logic [7:0]            next_ch;
	logic                  take_fill;
	logic                  take_sign;
	logic                  take_dig;

	assign tlen    = {{(WIDTH_BITS-4){1'b0}}, src.count} + {{(WIDTH_BITS-1){1'b0}}, src.neg};
	assign tot_in  = (src.width > tlen) ? src.width : tlen;
	assign idle    = (tot_q == '0);
	assign advance = !idle && (!out_valid_q || out_ch.ready);
	assign fill_ch = zpad_q ? CH_ZERO : CH_SPACE;

	always_comb begin
		take_fill = 1'b0;
		take_sign = 1'b0;
		take_dig  = 1'b0;
		next_ch   = fill_ch;
		priority if (!ladj_q && fill_q != '0) begin
			take_fill = 1'b1;
		end else if (sign_q) begin
			take_sign = 1'b1;
			next_ch   = CH_MINUS;
		end else if (dig_q != 4'd0) begin
			take_dig = 1'b1;
			next_ch  = digit_char(digits_q[STORE_BITS-1 -: 4]);
		end else begin
			take_fill = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q       <= '0;
			fill_q      <= '0;
			dig_q       <= '0;
			sign_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (start && idle) begin
				tot_q  <= tot_in;
				fill_q <= tot_in - tlen;
				dig_q  <= src.count;
				sign_q <= src.neg;
			end else if (advance) begin
				tot_q <= tot_q - WIDTH_BITS'(1);
				if (take_fill)
					fill_q <= fill_q - WIDTH_BITS'(1);
				if (take_sign)
					sign_q <= 1'b0;
				if (take_dig)
					dig_q <= dig_q - 4'd1;
			end
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start && idle) begin
			digits_q <= src.digits;
			ladj_q   <= src.left_adjust;
			zpad_q   <= src.zero_pad;
		end else if (advance && take_dig) begin
			digits_q <= {digits_q[STORE_BITS-5:0], 4'd0};
		end
		if (advance) begin
			char_q <= next_ch;
			last_q <= (tot_q == {{(WIDTH_BITS-1){1'b0}}, 1'b1});
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.character = char_q;
	assign out_ch.last      = last_q;

endmodule

`default_nettype wire

### hdl/integer_to_ascii_formatter.sv
// Integer to ASCII field formatter.
// Input channel in_ch carries a 32-bit word, a radix mode (signed decimal,
// hex, octal), a field width, a left-adjust flag and a zero-pad flag. Output
// channel out_ch returns the field one character per item, with last set on
// the final character. Both channels complete an item when valid and ready
// are high at a rising clock edge.
// Conversion: decimal runs a shift-add-3 unit one bit per cycle, hex and
// octal load their digits at once; a leading-zero strip then drops one
// digit per cycle (up to 10 digits). Once the conversion ends and the
// sender is idle, the result is handed to the sender, which registers
// each character before out_ch offers it. Characters then leave at one
// per cycle while the receiver is ready, and the next item converts
// while the previous field is still being sent.
// in_ch.ready is high only while the converter is free.
// Reset clears all control state; no item is in flight after reset.
// A stalled receiver holds the current character and freezes the sender;
// a finished conversion waits until the sender drains.
`default_nettype none

module integer_to_ascii_formatter import iaf_pkg::*; #(
	parameter int MAX_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	iaf_in_if.sink    in_ch,
	iaf_out_if.source out_ch
);

	localparam logic [WIDTH_BITS-1:0] MAX_W = WIDTH_BITS'(MAX_WIDTH);

	iaf_item_t             item;
	iaf_conv_t             conv_res;
	logic [WIDTH_BITS-1:0] width_in;
	logic                  conv_ready;
	logic                  conv_valid;
	logic                  emit_idle;
	logic                  hand_off;

	assign width_in = ({1'b0, in_ch.field_width} > MAX_W) ? MAX_W : {1'b0, in_ch.field_width};
	assign item     = '{value: in_ch.value, operation: in_ch.operation, width: width_in,
		left_adjust: in_ch.left_adjust, zero_pad: in_ch.zero_pad};
	assign hand_off = conv_valid && emit_idle;

	iaf_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_ch.valid),
		.item      (item),
		.ready     (conv_ready),
		.res_valid (conv_valid),
		.res_take  (hand_off),
		.res       (conv_res)
	);

	iaf_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hand_off),
		.src    (conv_res),
		.idle   (emit_idle),
		.out_ch (out_ch)
	);

	assign in_ch.ready = conv_ready;

endmodule

`default_nettype wire

### hdl/iaf_checker.sv
`default_nettype none

module iaf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] character,
	input logic       last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last))
		else $error("output item changed while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("converter took a second item while busy");

	a_legal_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (character >= 8'h30 && character <= 8'h39) ||
			(character >= 8'h41 && character <= 8'h46) ||
			character == 8'h20 || character == 8'h2D)
		else $error("character outside the digit, fill and sign set");

endmodule

bind integer_to_ascii_formatter iaf_checker u_iaf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.character (out_ch.character),
	.last      (out_ch.last)
);

`default_nettype wire
